// ===== rtl/core/text_terminal_scrollback_core_defines.svh =====
// assertion macros shared by the scrollback terminal rtl
// no dependencies; included by text_terminal_scrollback_core, which carries assertions
`ifndef TEXT_TERMINAL_SCROLLBACK_CORE_DEFINES_SVH
`define TEXT_TERMINAL_SCROLLBACK_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tts assertion failed");
// next-cycle implication
`define TTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tts assertion failed");
`else
`define TTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TTS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/tts_pkg.sv =====
// package for the scrollback terminal: geometry, widths, codes, beat types
// no dependencies
package tts_pkg;

    // geometry
    localparam int TEXT_COLUMNS  = 80;
    localparam int VISIBLE_ROWS  = 24;
    localparam int HISTORY_LINES = 512;
    localparam int TAB_STOP      = 8;

    // fixed field widths of the beats
    localparam int REQ_TYPE_W      = 2;
    localparam int CHAR_W          = 8;
    localparam int SCROLL_LINES_W  = 9;
    localparam int READ_ROW_W      = 5;
    localparam int DISPLAY_COL_W   = 7;
    localparam int CURSOR_ROW_W    = 5;
    localparam int CURSOR_COL_W    = 7;
    localparam int VIEW_OFFSET_W   = 9;
    localparam int LINES_HELD_W    = 10;

    // internal widths derived from the geometry
    localparam int SLOT_W = $clog2(HISTORY_LINES);
    localparam int HELD_W = $clog2(HISTORY_LINES + 1);
    localparam int ROW_W  = (VISIBLE_ROWS > 1) ? $clog2(VISIBLE_ROWS) : 1;
    localparam int COL_W  = $clog2(TEXT_COLUMNS);
    localparam int COLX_W = $clog2(TEXT_COLUMNS + TAB_STOP);
    localparam int SUM_W  = SLOT_W + 3;
    localparam int SCRL_W = ((SLOT_W > SCROLL_LINES_W) ? SLOT_W : SCROLL_LINES_W) + 1;

    // reset values of the ring pointers
    localparam logic [SLOT_W-1:0] SLOT_RST  = SLOT_W'(VISIBLE_ROWS % HISTORY_LINES);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_LINES - 1);
    localparam logic [HELD_W-1:0] HELD_RST  =
        HELD_W'((VISIBLE_ROWS < HISTORY_LINES) ? VISIBLE_ROWS : HISTORY_LINES);

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_OLDER = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_NEWER = 2'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd3;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

    // input beat
    typedef struct packed {
        logic [REQ_TYPE_W-1:0]     req_type;
        logic [CHAR_W-1:0]         char_code;
        logic [SCROLL_LINES_W-1:0] scroll_lines;
        logic [READ_ROW_W-1:0]     read_row;
        logic [DISPLAY_COL_W-1:0]  display_col;
    } t_in_item;

    // output beat
    typedef struct packed {
        logic [CHAR_W-1:0]        cell_char;
        logic [CURSOR_ROW_W-1:0]  cursor_row_out;
        logic [CURSOR_COL_W-1:0]  cursor_col_out;
        logic [VIEW_OFFSET_W-1:0] view_offset_out;
        logic [LINES_HELD_W-1:0]  lines_held_out;
    } t_out_item;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_BLANK,
        S_RDATA,
        S_DONE
    } t_state;

    // put-character classes
    typedef enum logic [2:0] {
        PK_IGNORE,
        PK_FF,
        PK_LF,
        PK_CR,
        PK_BS,
        PK_TAB,
        PK_PRINT
    } t_put_kind;

    // bring a ring sum below HISTORY_LINES (input below three times the ring)
    function automatic logic [SLOT_W-1:0] ring_reduce(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] t;
        t = v;
        if (t >= SUM_W'(HISTORY_LINES)) t = t - SUM_W'(HISTORY_LINES);
        if (t >= SUM_W'(HISTORY_LINES)) t = t - SUM_W'(HISTORY_LINES);
        return SLOT_W'(t);
    endfunction

    // deepest allowed scrollback for a given line count
    function automatic logic [SLOT_W-1:0] deepest_offset(input logic [HELD_W-1:0] held);
        logic [SLOT_W-1:0] m;
        m = '0;
        if (int'(held) > VISIBLE_ROWS) m = SLOT_W'(int'(held) - VISIBLE_ROWS);
        return m;
    endfunction

endpackage

// ===== rtl/core/text_terminal_scrollback_core.sv =====
// text terminal with a scrollback ring of lines, top level
// depends on tts_pkg and text_terminal_scrollback_core_defines.svh
//
// usage: one request beat in on i_in_valid/o_in_stall (put character,
// scroll older, scroll newer, read cell), one result beat out on
// o_out_valid/i_out_stall carrying the read character and the cursor,
// view offset and line count after the request.
// the line ring is one memory of HISTORY_LINES rows, TEXT_COLUMNS bytes
// wide, with per-byte write enables and one registered read port; one
// request is worked at a time, so every write lands before the next read.
// each request passes S_EXEC and then S_DONE; a new line adds S_BLANK, a
// read adds S_RDATA, and a form feed sweeps the ring one row per cycle in
// S_CLEAR before S_DONE. a new request is taken only after the last one
// has left S_DONE. after reset the same sweep runs over every ring row
// with o_in_stall high and no result. a stalled result sits in the output
// register; the next request is taken meanwhile and waits for the register
// to free up.
module text_terminal_scrollback_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tts_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tts_pkg::t_out_item  o_out_data
);
    import tts_pkg::*;

`include "text_terminal_scrollback_core_defines.svh"

    // line ring memory
    logic [TEXT_COLUMNS-1:0][CHAR_W-1:0] r_line_mem [HISTORY_LINES];
    logic [TEXT_COLUMNS-1:0][CHAR_W-1:0] r_rd_line;

    // control and terminal state
    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_clr_idx, n_clr_idx;
    logic              r_clr_reply, n_clr_reply;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_top, n_top;
    logic [HELD_W-1:0] r_held, n_held;
    logic [SLOT_W-1:0] r_view, n_view;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic              r_out_valid, n_out_valid;

    // payload registers
    t_in_item          r_req;
    logic [SLOT_W-1:0] r_blank_slot, n_blank_slot;
    logic              r_rd_ok, n_rd_ok;
    logic [COL_W-1:0]  r_rd_col, n_rd_col;
    logic [CHAR_W-1:0] r_cell, n_cell;
    t_out_item         r_out;

    // memory port controls
    logic                    wr_en;
    logic [SLOT_W-1:0]       wr_addr;
    logic [TEXT_COLUMNS-1:0] wr_be;
    logic [CHAR_W-1:0]       wr_byte;
    logic                    rd_en;
    logic [SLOT_W-1:0]       rd_addr;

    // decode and arithmetic
    logic              in_accept;
    logic              out_load;
    t_put_kind         put_kind;
    logic [COLX_W-1:0] col_inc;
    logic [COLX_W-1:0] col_tab;
    logic              last_row;
    logic              wrap;
    logic              opens_line;
    logic [HELD_W-1:0] held_nl;
    logic [SLOT_W-1:0] max_nl;
    logic [SLOT_W:0]   view_inc;
    logic [SLOT_W-1:0] char_slot;
    logic [SLOT_W-1:0] read_base;
    logic [SLOT_W-1:0] read_slot;
    logic              read_ok;
    logic [SCRL_W-1:0] scroll_sum;
    logic [SCRL_W-1:0] scroll_max;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // classify the put byte
    always_comb begin
        case (r_req.char_code) inside
            CH_FF:              put_kind = PK_FF;
            CH_LF:              put_kind = PK_LF;
            CH_CR:              put_kind = PK_CR;
            CH_BS:              put_kind = PK_BS;
            CH_TAB:             put_kind = PK_TAB;
            [CH_SPACE:CH_TILDE]: put_kind = PK_PRINT;
            default:            put_kind = PK_IGNORE;
        endcase
    end

    // cursor motion and new-line detection
    assign col_inc  = COLX_W'(r_col) + COLX_W'(1);
    assign col_tab  = (COLX_W'(r_col) + COLX_W'(TAB_STOP)) & ~COLX_W'(TAB_STOP - 1);
    assign last_row = (r_row == ROW_W'(VISIBLE_ROWS - 1));
    assign wrap     = (put_kind == PK_LF)
                   || ((put_kind == PK_PRINT) && (col_inc >= COLX_W'(TEXT_COLUMNS)))
                   || ((put_kind == PK_TAB) && (col_tab >= COLX_W'(TEXT_COLUMNS)));
    assign opens_line = (r_req.req_type == REQ_PUT) && wrap && last_row;

    // line count and view clamp after a new line
    assign held_nl  = (r_held < HELD_W'(HISTORY_LINES)) ? r_held + HELD_W'(1) : r_held;
    assign max_nl   = deepest_offset(held_nl);
    assign view_inc = {1'b0, r_view} + (SLOT_W + 1)'(1);

    // ring addresses for a put and for a read
    assign char_slot = ring_reduce(SUM_W'(r_top) + SUM_W'(r_row));
    assign read_base = ring_reduce(SUM_W'(r_top) + SUM_W'(ROW_W'(r_req.read_row)));
    assign read_slot = ring_reduce(SUM_W'(read_base) + SUM_W'(HISTORY_LINES)
                                   - SUM_W'(r_view));
    assign read_ok   = (int'(r_req.read_row) < VISIBLE_ROWS)
                    && (int'(r_req.display_col) < TEXT_COLUMNS);

    // scroll toward older text
    assign scroll_sum = SCRL_W'(r_view) + SCRL_W'(r_req.scroll_lines);
    assign scroll_max = SCRL_W'(deepest_offset(r_held));

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == SLOT_LAST) n_state = r_clr_reply ? S_DONE : S_IDLE;
            end
            S_IDLE: begin
                if (in_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_req.req_type)
                    REQ_PUT: begin
                        if (put_kind == PK_FF)  n_state = S_CLEAR;
                        else if (opens_line)    n_state = S_BLANK;
                        else                    n_state = S_DONE;
                    end
                    REQ_READ: n_state = S_RDATA;
                    default:  n_state = S_DONE;
                endcase
            end
            S_BLANK: n_state = S_DONE;
            S_RDATA: n_state = S_DONE;
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: memory port and input stall
    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = r_blank_slot;
        wr_be      = '1;
        wr_byte    = CH_SPACE;
        rd_en      = 1'b0;
        rd_addr    = read_slot;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_idx;
            end
            S_EXEC: begin
                if ((r_req.req_type == REQ_PUT) && (put_kind == PK_PRINT)) begin
                    wr_en   = 1'b1;
                    wr_addr = char_slot;
                    wr_be   = TEXT_COLUMNS'(1) << r_col;
                    wr_byte = r_req.char_code;
                end
                rd_en = (r_req.req_type == REQ_READ);
            end
            S_BLANK: wr_en = 1'b1;
            default: wr_en = 1'b0;
        endcase
    end

    // terminal state update
    always_comb begin
        n_clr_idx    = r_clr_idx;
        n_clr_reply  = r_clr_reply;
        n_slot       = r_slot;
        n_top        = r_top;
        n_held       = r_held;
        n_view       = r_view;
        n_row        = r_row;
        n_col        = r_col;
        n_blank_slot = r_blank_slot;
        n_rd_ok      = r_rd_ok;
        n_rd_col     = r_rd_col;
        n_cell       = r_cell;
        n_out_valid  = out_load ? 1'b1 : (r_out_valid && i_out_stall);
        case (r_state)
            S_CLEAR: n_clr_idx = r_clr_idx + SLOT_W'(1);
            S_EXEC: begin
                n_cell = '0;
                case (r_req.req_type)
                    REQ_PUT: begin
                        if (put_kind == PK_FF) begin
                            n_clr_idx   = '0;
                            n_clr_reply = 1'b1;
                            n_slot      = SLOT_RST;
                            n_top       = '0;
                            n_held      = HELD_RST;
                            n_view      = '0;
                            n_row       = '0;
                            n_col       = '0;
                        end else begin
                            // cursor
                            if (wrap) begin
                                n_col = '0;
                                n_row = last_row ? r_row : r_row + ROW_W'(1);
                            end else begin
                                case (put_kind)
                                    PK_PRINT: n_col = COL_W'(col_inc);
                                    PK_TAB:   n_col = COL_W'(col_tab);
                                    PK_CR:    n_col = '0;
                                    PK_BS:    n_col = (r_col != '0) ? r_col - COL_W'(1) : r_col;
                                    default:  n_col = r_col;
                                endcase
                            end
                            // new line: retire the oldest ring row
                            if (opens_line) begin
                                n_blank_slot = r_slot;
                                n_slot = (r_slot == SLOT_LAST) ? '0 : r_slot + SLOT_W'(1);
                                n_top  = (r_top == SLOT_LAST) ? '0 : r_top + SLOT_W'(1);
                                n_held = held_nl;
                                if (r_view != '0) begin
                                    n_view = (view_inc > {1'b0, max_nl}) ? max_nl
                                                                         : SLOT_W'(view_inc);
                                end
                            end
                            // typing and newline return to the bottom
                            if ((put_kind == PK_PRINT) || (put_kind == PK_LF)) n_view = '0;
                        end
                    end
                    REQ_OLDER: begin
                        n_view = (scroll_sum > scroll_max) ? SLOT_W'(scroll_max)
                                                           : SLOT_W'(scroll_sum);
                    end
                    REQ_NEWER: begin
                        n_view = (SCRL_W'(r_req.scroll_lines) >= SCRL_W'(r_view)) ? '0
                               : SLOT_W'(SCRL_W'(r_view) - SCRL_W'(r_req.scroll_lines));
                    end
                    REQ_READ: begin
                        n_rd_ok  = read_ok;
                        n_rd_col = COL_W'(r_req.display_col);
                    end
                    default: n_cell = '0;
                endcase
            end
            S_RDATA: n_cell = r_rd_ok ? r_rd_line[r_rd_col] : '0;
            default: n_cell = r_cell;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_clr_reply <= 1'b0;
            r_slot      <= SLOT_RST;
            r_top       <= '0;
            r_held      <= HELD_RST;
            r_view      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_clr_reply <= n_clr_reply;
            r_slot      <= n_slot;
            r_top       <= n_top;
            r_held      <= n_held;
            r_view      <= n_view;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) r_req <= i_in_data;
        r_blank_slot <= n_blank_slot;
        r_rd_ok      <= n_rd_ok;
        r_rd_col     <= n_rd_col;
        r_cell       <= n_cell;
        if (out_load) begin
            r_out.cell_char       <= r_cell;
            r_out.cursor_row_out  <= CURSOR_ROW_W'(r_row);
            r_out.cursor_col_out  <= CURSOR_COL_W'(r_col);
            r_out.view_offset_out <= VIEW_OFFSET_W'(r_view);
            r_out.lines_held_out  <= LINES_HELD_W'(r_held);
        end
    end

    // ring memory write port, byte enables per column
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int c = 0; c < TEXT_COLUMNS; c++) begin
                if (wr_be[c]) r_line_mem[wr_addr][c] <= wr_byte;
            end
        end
    end

    // ring memory read port, registered row
    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_line <= r_line_mem[rd_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `TTS_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, in_accept, r_state == S_EXEC)
    `TTS_ASSERT_IMP(a_view_clamped, i_clk, i_rst_n, r_state == S_IDLE, r_view <= deepest_offset(r_held))
    `TTS_ASSERT_IMP(a_cursor_range, i_clk, i_rst_n, r_state == S_IDLE, (int'(r_row) < VISIBLE_ROWS) && (int'(r_col) < TEXT_COLUMNS))
    `TTS_ASSERT_NXT(a_clear_ends, i_clk, i_rst_n, (r_state == S_CLEAR) && (r_clr_idx == SLOT_LAST), r_state != S_CLEAR)
    `TTS_ASSERT_IMP(a_held_range, i_clk, i_rst_n, 1'b1, (r_held >= HELD_RST) && (r_held <= HELD_W'(HISTORY_LINES)))

endmodule

// ===== test/text_terminal_scrollback_core_tb.sv =====
// testbench for text_terminal_scrollback_core: directed and random request beats checked
// against a behavioral terminal model kept in this file
// depends on tts_pkg and the rtl of text_terminal_scrollback_core
module text_terminal_scrollback_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 20;

    logic      i_clk;
    logic      rst_n     = 1'b0;
    logic      tx_valid  = 1'b0;
    t_in_item  tx_data   = '0;
    logic      rx_stall  = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    // idle and hold controls shared by the test tasks and the stall process
    bit tx_idle_en  = 1'b1;
    bit rx_idle_en  = 1'b1;
    bit rx_hold_req = 1'b0;

    t_out_item expect_q[$];
    int        n_errors   = 0;
    int        n_cycles   = 0;
    int        n_checked  = 0;
    int        n_puts     = 0;
    int        n_scrolls  = 0;
    int        n_reads    = 0;
    int        n_clears   = 0;
    int        n_opened_lines = 0;

    // shadow copy of the terminal state
    bit [7:0] shadow_text [HISTORY_LINES][TEXT_COLUMNS];
    int       top_slot;
    int       line_count;
    int       scroll_back;
    int       crs_row;
    int       crs_col;

    text_terminal_scrollback_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (tx_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (tx_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (rx_stall),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------- terminal model ----------------

    function automatic void wipe_all();
        for (int l = 0; l < HISTORY_LINES; l++) begin
            for (int c = 0; c < TEXT_COLUMNS; c++) begin
                shadow_text[l][c] = CH_SPACE;
            end
        end
        top_slot    = VISIBLE_ROWS % HISTORY_LINES;
        line_count  = (VISIBLE_ROWS < HISTORY_LINES) ? VISIBLE_ROWS : HISTORY_LINES;
        scroll_back = 0;
        crs_row     = 0;
        crs_col     = 0;
    endfunction

    function automatic int deepest_view();
        return (line_count > VISIBLE_ROWS) ? line_count - VISIBLE_ROWS : 0;
    endfunction

    function automatic int ring_slot(input int line);
        int t;
        t = line % HISTORY_LINES;
        if (t < 0) t += HISTORY_LINES;
        return t;
    endfunction

    // blank the oldest line and advance the ring, keeping a scrolled view on its text
    function automatic void open_line();
        int m;
        for (int c = 0; c < TEXT_COLUMNS; c++) shadow_text[top_slot][c] = CH_SPACE;
        top_slot = (top_slot + 1) % HISTORY_LINES;
        if (line_count < HISTORY_LINES) line_count++;
        if (scroll_back > 0) begin
            m = deepest_view();
            scroll_back++;
            if (scroll_back > m) scroll_back = m;
        end
        n_opened_lines++;
    endfunction

    function automatic void step_row();
        crs_col = 0;
        crs_row++;
        if (crs_row >= VISIBLE_ROWS) begin
            crs_row = VISIBLE_ROWS - 1;
            open_line();
        end
    endfunction

    function automatic void put_char(input logic [CHAR_W-1:0] ch);
        int ln;
        case (ch)
            CH_FF: begin
                wipe_all();
                n_clears++;
            end
            CH_LF: begin
                step_row();
                scroll_back = 0;
            end
            CH_CR: crs_col = 0;
            CH_BS: begin
                if (crs_col > 0) crs_col--;
            end
            CH_TAB: begin
                crs_col = (crs_col / TAB_STOP + 1) * TAB_STOP;
                if (crs_col >= TEXT_COLUMNS) step_row();
            end
            default: begin
                if (ch >= CH_SPACE && ch <= CH_TILDE) begin
                    ln = ring_slot(top_slot - (VISIBLE_ROWS - crs_row));
                    shadow_text[ln][crs_col] = ch;
                    crs_col++;
                    if (crs_col >= TEXT_COLUMNS) step_row();
                    scroll_back = 0;
                end
            end
        endcase
    endfunction

    // apply one request to the shadow state and return the beat it should produce
    function automatic t_out_item terminal_step(input t_in_item req);
        t_out_item res;
        int        m;
        int        ln;
        logic [CHAR_W-1:0] cell_val;
        cell_val = '0;
        case (req.req_type)
            REQ_PUT: begin
                put_char(req.char_code);
                n_puts++;
            end
            REQ_OLDER: begin
                m = deepest_view();
                scroll_back += int'(req.scroll_lines);
                if (scroll_back > m) scroll_back = m;
                n_scrolls++;
            end
            REQ_NEWER: begin
                if (int'(req.scroll_lines) >= scroll_back) scroll_back = 0;
                else scroll_back -= int'(req.scroll_lines);
                n_scrolls++;
            end
            default: begin
                if (req.read_row < VISIBLE_ROWS && req.display_col < TEXT_COLUMNS) begin
                    ln = ring_slot(top_slot - VISIBLE_ROWS + int'(req.read_row)
                                   - scroll_back);
                    cell_val = shadow_text[ln][req.display_col];
                end
                n_reads++;
            end
        endcase
        res.cell_char       = cell_val;
        res.cursor_row_out  = CURSOR_ROW_W'(crs_row);
        res.cursor_col_out  = CURSOR_COL_W'(crs_col);
        res.view_offset_out = VIEW_OFFSET_W'(scroll_back);
        res.lines_held_out  = LINES_HELD_W'(line_count);
        return res;
    endfunction

    // ---------------- random pickers ----------------

    // idle length: mostly none, sometimes short, rarely long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return CHAR_W'($urandom_range(CH_SPACE, CH_TILDE));
        if (r < 60) return CH_LF;
        if (r < 67) return CH_CR;
        if (r < 75) return CH_BS;
        if (r < 85) return CH_TAB;
        if (r < 86) return CH_FF;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // mostly visible rows, sometimes the whole field range
    function automatic logic [READ_ROW_W-1:0] pick_row();
        if ($urandom_range(0, 9) != 0) return READ_ROW_W'($urandom_range(0, VISIBLE_ROWS - 1));
        return READ_ROW_W'($urandom);
    endfunction

    function automatic logic [DISPLAY_COL_W-1:0] pick_col();
        if ($urandom_range(0, 9) != 0) return DISPLAY_COL_W'($urandom_range(0, TEXT_COLUMNS - 1));
        return DISPLAY_COL_W'($urandom);
    endfunction

    function automatic logic [SCROLL_LINES_W-1:0] pick_lines();
        if ($urandom_range(0, 3) != 0) return SCROLL_LINES_W'($urandom_range(0, 40));
        return SCROLL_LINES_W'($urandom);
    endfunction

    // request of a given kind with random content in the fields it does not use
    function automatic t_in_item noisy_req(input logic [REQ_TYPE_W-1:0] kind);
        t_in_item r;
        r.req_type     = kind;
        r.char_code    = CHAR_W'($urandom);
        r.scroll_lines = SCROLL_LINES_W'($urandom);
        r.read_row     = READ_ROW_W'($urandom);
        r.display_col  = DISPLAY_COL_W'($urandom);
        return r;
    endfunction

    // ---------------- request side ----------------

    // offer one beat, wait for it to be taken, then predict and maybe idle
    task automatic send_req(input t_in_item req);
        int gap;
        tx_valid <= 1'b1;
        tx_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expect_q.push_back(terminal_step(req));
        gap = tx_idle_en ? gap_len() : 0;
        if (gap != 0) begin
            tx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_put(input logic [CHAR_W-1:0] ch);
        t_in_item r;
        r = noisy_req(REQ_PUT);
        r.char_code = ch;
        send_req(r);
    endtask

    task automatic send_scroll(input logic [REQ_TYPE_W-1:0] kind,
                               input logic [SCROLL_LINES_W-1:0] n);
        t_in_item r;
        r = noisy_req(kind);
        r.scroll_lines = n;
        send_req(r);
    endtask

    task automatic send_read(input logic [READ_ROW_W-1:0] row,
                             input logic [DISPLAY_COL_W-1:0] col);
        t_in_item r;
        r = noisy_req(REQ_READ);
        r.read_row    = row;
        r.display_col = col;
        send_req(r);
    endtask

    // ---------------- result side ----------------

    // result stall: random runs, or one long counted hold on request
    initial begin : rx_stall_gen
        int n;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else if (!rx_idle_en) begin
                rx_stall <= 1'b0;
            end else begin
                n = gap_len();
                rx_stall <= (n != 0);
                if (n > 1) repeat (n - 1) @(posedge i_clk);
            end
        end
    end

    // compare each taken result beat with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (rst_n && o_out_valid && !rx_stall) begin
            if (expect_q.size() == 0) begin
                $error("result beat with no request outstanding: %h", o_out_data);
                n_errors++;
            end else begin
                want = expect_q.pop_front();
                n_checked++;
                if (o_out_data.cell_char !== want.cell_char) begin
                    $error("cell_char expected %0d got %0d",
                           want.cell_char, o_out_data.cell_char);
                    n_errors++;
                end
                if (o_out_data.cursor_row_out !== want.cursor_row_out) begin
                    $error("cursor_row_out expected %0d got %0d",
                           want.cursor_row_out, o_out_data.cursor_row_out);
                    n_errors++;
                end
                if (o_out_data.cursor_col_out !== want.cursor_col_out) begin
                    $error("cursor_col_out expected %0d got %0d",
                           want.cursor_col_out, o_out_data.cursor_col_out);
                    n_errors++;
                end
                if (o_out_data.view_offset_out !== want.view_offset_out) begin
                    $error("view_offset_out expected %0d got %0d",
                           want.view_offset_out, o_out_data.view_offset_out);
                    n_errors++;
                end
                if (o_out_data.lines_held_out !== want.lines_held_out) begin
                    $error("lines_held_out expected %0d got %0d",
                           want.lines_held_out, o_out_data.lines_held_out);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------- tests ----------------

    // field extremes, every control byte, ignored bytes, reads off the screen
    task automatic test_directed();
        send_read(READ_ROW_W'(0), DISPLAY_COL_W'(0));
        send_put(CH_SPACE);
        send_put(CH_TILDE);
        send_put(8'h00);
        send_put(8'h1F);
        send_put(8'h7F);
        send_put(8'hFF);
        send_put(CH_BS);
        send_put(CH_BS);
        send_put(CH_BS);
        send_put(CH_TAB);
        send_put(CH_CR);
        send_put(CH_LF);
        send_read(READ_ROW_W'(0), DISPLAY_COL_W'(1));
        send_read(READ_ROW_W'(VISIBLE_ROWS), DISPLAY_COL_W'(0));
        send_read(5'd31, 7'd127);
        send_read(READ_ROW_W'(0), DISPLAY_COL_W'(TEXT_COLUMNS));
        send_read(READ_ROW_W'(VISIBLE_ROWS - 1), DISPLAY_COL_W'(TEXT_COLUMNS - 1));
        send_scroll(REQ_OLDER, 9'd511);
        send_scroll(REQ_NEWER, 9'd511);
        send_scroll(REQ_NEWER, 9'd0);
        send_put(CH_FF);
    endtask

    // enough lines to fill the ring and wrap it, with peeks into the history
    task automatic test_history_wrap();
        for (int i = 0; i < 560; i++) begin
            tx_idle_en = (i >= 200);
            rx_idle_en = (i >= 120);
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3))
                    send_put(CHAR_W'($urandom_range(CH_SPACE, CH_TILDE)));
            end
            send_put(CH_LF);
            if (i % 20 == 19) begin
                send_scroll(REQ_OLDER, SCROLL_LINES_W'($urandom));
                send_read(pick_row(), pick_col());
                send_read(pick_row(), pick_col());
                send_scroll(REQ_NEWER, pick_lines());
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // view held back while text arrives: tab wraps, reads, partial scrolls
    task automatic test_scroll_back();
        for (int i = 0; i < 45; i++) begin
            send_scroll(REQ_OLDER, ($urandom_range(0, 1) != 0) ? SCROLL_LINES_W'($urandom)
                                                               : pick_lines());
            repeat ($urandom_range(1, 3)) send_read(pick_row(), pick_col());
            case ($urandom_range(0, 3))
                0: repeat ($urandom_range(1, 12)) send_put(CH_TAB);
                1: begin
                    send_put(CH_CR);
                    send_put(CH_BS);
                end
                2: send_put(pick_char());
                default: send_scroll(REQ_NEWER, pick_lines());
            endcase
            send_read(pick_row(), pick_col());
        end
    endtask

    // results held off for a long stretch while requests keep coming
    task automatic test_back_pressure();
        tx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
        repeat (40) begin
            if ($urandom_range(0, 2) == 0) send_read(pick_row(), pick_col());
            else send_put(pick_char());
        end
        tx_idle_en = 1'b1;
    endtask

    // unconstrained mix of every request kind
    task automatic test_random_mix();
        int r;
        repeat (340) begin
            r = $urandom_range(0, 99);
            if (r < 50) send_put(pick_char());
            else if (r < 65) send_scroll(REQ_OLDER, pick_lines());
            else if (r < 80) send_scroll(REQ_NEWER, pick_lines());
            else send_read(pick_row(), pick_col());
        end
    endtask

    // reset, run the tests in turn, drain and report
    initial begin
        wipe_all();
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_history_wrap();
        test_scroll_back();
        test_back_pressure();
        test_random_mix();

        tx_valid <= 1'b0;
        while (expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d result beats: %0d puts, %0d scrolls, %0d reads, %0d clears",
                 n_checked, n_puts, n_scrolls, n_reads, n_clears);
        $display("%0d new lines opened, ring wrapped with the view both at bottom and held back",
                 n_opened_lines);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
